[rtl/bbr_pkg.sv]
// shared types and constants for the byte bank reduce unit
`default_nettype none

package bbr_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_MUL = 3'd1;
  localparam logic [2:0] OP_OR  = 3'd2;
  localparam logic [2:0] OP_XOR = 3'd3;
  localparam logic [2:0] OP_AND = 3'd4;
  localparam logic [2:0] OP_MIN = 3'd5;
  localparam logic [2:0] OP_MAX = 3'd6;
  localparam logic [2:0] OP_AVG = 3'd7;

  localparam logic [0:0] REG_OPERATION = 1'b0;
  localparam logic [0:0] REG_BANK_SIZE = 1'b1;

  localparam logic [2:0] OPERATION_RESET = OP_ADD;
  localparam logic [7:0] DEFAULT_BANK    = 8'd2;

  localparam int         DIV_STEPS = 16;
  localparam logic [3:0] DIV_LAST  = 4'(DIV_STEPS - 1);

  typedef struct packed {
    logic take;
    logic div_step;
    logic load_out;
  } bbr_cmd_t;

  typedef struct packed {
    logic bank_end;
    logic is_avg;
    logic div_last;
  } bbr_status_t;

endpackage

`default_nettype wire

[rtl/bbr_datapath.sv]
// datapath: config registers, bank fold, serial divider and output byte register
`default_nettype none

module bbr_datapath #(
  parameter int MAX_BANK = 255
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic signed [7:0]  in_sample,
  input  wire bbr_pkg::bbr_cmd_t  cmd,
  output bbr_pkg::bbr_status_t    status,
  output logic [7:0]              out_result_byte
);

  localparam int         LIMIT_INT  = (MAX_BANK > 255) ? 255 : MAX_BANK;
  localparam logic [7:0] SIZE_LIMIT = 8'(LIMIT_INT);

  logic [2:0]         op_r;
  logic [7:0]         bank_size_r;
  logic signed [15:0] acc_r;
  logic [7:0]         count_r;
  logic [15:0]        quo_r;
  logic [7:0]         rem_r;
  logic [7:0]         divisor_r;
  logic               neg_r;
  logic [3:0]         div_cnt_r;
  logic [7:0]         out_byte_r;

  logic [7:0]         eff_size;
  logic signed [15:0] sample_ext;
  logic signed [31:0] product;
  logic signed [15:0] combined;
  logic signed [15:0] acc_nxt;
  logic [8:0]         taken;
  logic [15:0]        acc_mag;
  logic [8:0]         rem_shift;
  logic [8:0]         rem_sub;
  logic               rem_fits;
  logic [7:0]         emit_byte;

  always_comb begin
    if (bank_size_r == 8'd0) begin
      eff_size = bbr_pkg::DEFAULT_BANK;
    end else if (bank_size_r > SIZE_LIMIT) begin
      eff_size = SIZE_LIMIT;
    end else begin
      eff_size = bank_size_r;
    end
  end

  assign sample_ext = 16'(in_sample);
  assign product    = acc_r * sample_ext;

  always_comb begin
    unique case (op_r)
      bbr_pkg::OP_ADD: combined = acc_r + sample_ext;
      bbr_pkg::OP_MUL: combined = product[15:0];
      bbr_pkg::OP_OR:  combined = acc_r | sample_ext;
      bbr_pkg::OP_XOR: combined = acc_r ^ sample_ext;
      bbr_pkg::OP_AND: combined = acc_r & sample_ext;
      bbr_pkg::OP_MIN: combined = (acc_r < sample_ext) ? acc_r : sample_ext;
      bbr_pkg::OP_MAX: combined = (acc_r > sample_ext) ? acc_r : sample_ext;
      bbr_pkg::OP_AVG: combined = acc_r + sample_ext;
    endcase
  end

  assign acc_nxt = (count_r == 8'd0) ? sample_ext : combined;
  assign taken   = {1'b0, count_r} + 9'd1;
  assign acc_mag = acc_nxt[15] ? 16'(-acc_nxt) : 16'(acc_nxt);

  // restoring divider, one quotient bit per cycle
  assign rem_shift = {rem_r, quo_r[15]};
  assign rem_fits  = rem_shift >= {1'b0, divisor_r};
  assign rem_sub   = rem_shift - {1'b0, divisor_r};
  assign emit_byte = neg_r ? 8'(8'd0 - quo_r[7:0]) : quo_r[7:0];

  assign status.bank_end = taken >= {1'b0, eff_size};
  assign status.is_avg   = op_r == bbr_pkg::OP_AVG;
  assign status.div_last = div_cnt_r == bbr_pkg::DIV_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= bbr_pkg::OPERATION_RESET;
      bank_size_r <= bbr_pkg::DEFAULT_BANK;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bbr_pkg::REG_OPERATION: op_r        <= cfg_data[2:0];
        bbr_pkg::REG_BANK_SIZE: bank_size_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      count_r <= '0;
    end else if (cmd.take) begin
      if (status.bank_end) begin
        acc_r   <= '0;
        count_r <= '0;
      end else begin
        acc_r   <= acc_nxt;
        count_r <= taken[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.bank_end) begin
      quo_r     <= status.is_avg ? acc_mag : 16'(acc_nxt);
      neg_r     <= status.is_avg && acc_nxt[15];
      rem_r     <= '0;
      div_cnt_r <= '0;
      divisor_r <= eff_size;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[14:0], rem_fits};
      rem_r     <= rem_fits ? rem_sub[7:0] : rem_shift[7:0];
      div_cnt_r <= div_cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r <= emit_byte;
    end
  end

  assign out_result_byte = out_byte_r;

  a_bank_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && status.bank_end |=> count_r == 8'd0)
    else $error("sample count not cleared after bank end");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && status.bank_end |=> divisor_r != 8'd0)
    else $error("zero divisor latched at bank end");

endmodule

`default_nettype wire

[rtl/bbr_ctrl.sv]
// controller: sample intake, divide sequencing and output valid
`default_nettype none

module bbr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire bbr_pkg::bbr_status_t status,
  output bbr_pkg::bbr_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    state_nxt    = state_r;
    cmd.take     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && status.bank_end) begin
          state_nxt = status.is_avg ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("output valid raised outside emit");

  a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && status.div_last |=> state_r == ST_EMIT)
    else $error("divider finished without emit");

  a_plain_bank_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && status.bank_end && !status.is_avg |=> state_r == ST_EMIT)
    else $error("bank end did not go to emit");

endmodule

`default_nettype wire

[rtl/byte_bank_reduce_unit.sv]
// top level of the byte bank reduce unit
// Folds signed 8-bit samples over banks of bank_size samples (0 means 2, sizes
// above MAX_BANK are clamped) with add, mul, or, xor, and, min, max or average,
// and emits the low byte of each bank's result as one output transaction.
// Within a bank one sample is taken per cycle. After the last sample of a bank
// no sample is taken while the output register is loaded, nor while the
// previous byte still waits there unaccepted; with average the bank sum first
// goes through a restoring divider at one quotient bit per cycle, during which
// no sample is taken. A finished byte waits in the output register while the
// next bank's samples are taken.
`default_nettype none

module byte_bank_reduce_unit #(
  parameter int MAX_BANK = 255
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [7:0] in_sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_result_byte
);

  bbr_pkg::bbr_cmd_t    cmd;
  bbr_pkg::bbr_status_t status;

  bbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bbr_datapath #(
    .MAX_BANK (MAX_BANK)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .status          (status),
    .out_result_byte (out_result_byte)
  );

endmodule

`default_nettype wire
